### hw/rtl/ptm_pkg.sv
// shared types and constants for the per-thread timeout manager
// no dependencies
package ptm_pkg;

  localparam int ThreadsDefault = 32;
  localparam logic [63:0] NsPerTick = 64'd52;
  localparam logic [63:0] FreqNs = 64'd998400000;
  localparam logic [63:0] Never = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [3:0] GuardReset = 4'd4;

  typedef enum logic [2:0] {
    REQ_FREQ = 3'd0,
    REQ_RES  = 3'd1,
    REQ_TIME = 3'd2,
    REQ_GET  = 3'd3,
    REQ_SET  = 3'd4,
    REQ_INT  = 3'd5
  } req_t;

endpackage

### hw/rtl/ptm_div52.sv
// sequential divide of a 64-bit value by 52, four quotient bits per cycle
// depends on ptm_pkg
module ptm_div52 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] num;
  logic [5:0]  rem;
  logic [3:0]  cnt;
  logic        busy;
  logic [9:0]  trial;
  logic [3:0]  digit;
  logic [5:0]  rem_next;

  // partial remainder with the next four dividend bits
  assign trial = {rem, num[63:60]};

  // quotient digit: largest multiple of 52 not above the trial value
  always_comb begin
    digit = 4'd0;
    rem_next = trial[5:0];
    for (int k = 1; k < 16; k++) begin
      if (trial >= 10'(k) * ptm_pkg::NsPerTick[9:0]) begin
        digit = 4'(k);
        rem_next = 6'(trial - 10'(k) * ptm_pkg::NsPerTick[9:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift quotient digits in as dividend digits move out
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= 6'd0;
    end else if (busy) begin
      rem <= rem_next;
      num <= {num[59:0], digit};
    end
  end

  assign quotient = num;

endmodule

### hw/rtl/per_thread_timeout_manager.sv
// per_thread_timeout_manager: deadline table in one synchronous memory
// one item at a time: a new item is taken only once the last one is through and its
// result has been accepted by the receiver; set timeout uses a radix-16 divide by 52,
// interrupt does a read-compare pass and a notice walk over the table
// reset: a clearing pass zeroes every table entry, no item taken
// until it ends; guard_ticks resets to 4, match to all ones
module per_thread_timeout_manager #(
  parameter int THREADS = ptm_pkg::ThreadsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // req_type[2:0], thread_id[7:3], arg_value[71:8], now_ticks[135:72]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,  // value[63:0], expired_thread[68:64], match_ticks[132:69]
  output logic         m_tuser,  // kind
  output logic         m_tlast   // last_of_run
);

  localparam int AW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int CW = $clog2(THREADS + 1);

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_RD   = 9'b000000100,
    S_GET  = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_SCAN = 9'b000100000,
    S_NOTE = 9'b001000000,
    S_OUT  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state;
  logic [63:0] mem [THREADS];
  logic [63:0] rdata;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata;

  logic [3:0]  guard;
  logic [63:0] last_time, match, best, limit;
  logic [2:0]  req;
  logic [4:0]  tid;
  logic        ok;
  logic [63:0] arg, now;
  logic [CW-1:0] idx;
  logic        rd_valid;
  logic [AW-1:0] rd_idx;
  logic [THREADS-1:0] hit;
  logic        div_start, div_done;
  logic [63:0] quot, ticks;
  logic        oval, okind, olast;
  logic [63:0] ovalue;
  logic [4:0]  othr;

  // memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  ptm_div52 u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(arg),
    .done(div_done), .quotient(quot)
  );

  assign ok = ({2'b00, tid} < 7'(THREADS));
  assign ticks = (arg == ptm_pkg::Never || quot <= last_time) ? 64'd0 : quot;
  assign s_tready = (state == S_IDLE) && !oval;
  assign div_start = (state == S_RD) && (req == ptm_pkg::REQ_SET) && ok;

  // memory port control
  always_comb begin
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = 64'd0;
    raddr = AW'(tid);
    case (state)
      S_CLR: we = 1'b1;
      S_DIV: begin
        waddr = AW'(tid);
        wdata = ticks;
        we = div_done;
      end
      S_SCAN: begin
        raddr = idx[AW-1:0];
        waddr = rd_idx;
        we = rd_valid && rdata != 64'd0 && rdata <= limit;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      idx <= '0;
      guard <= ptm_pkg::GuardReset;
      last_time <= 64'd0;
      match <= ptm_pkg::Never;
      oval <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (cfg_we) guard <= cfg_wdata;
      if (oval && m_tready) oval <= 1'b0;
      case (state)
        S_CLR: begin
          idx <= idx + CW'(1);
          if (idx == CW'(THREADS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            req <= s_tdata[2:0];
            tid <= s_tdata[7:3];
            arg <= s_tdata[71:8];
            now <= s_tdata[135:72];
            state <= S_RD;
          end
        end
        S_RD: begin
          okind <= 1'b0; othr <= 5'd0; olast <= 1'b1;
          case (req)
            ptm_pkg::REQ_FREQ: begin
              ovalue <= ptm_pkg::FreqNs; oval <= 1'b1; state <= S_IDLE;
            end
            ptm_pkg::REQ_RES: begin
              ovalue <= ptm_pkg::NsPerTick; oval <= 1'b1; state <= S_IDLE;
            end
            ptm_pkg::REQ_TIME: begin
              if (now > last_time) last_time <= now;
              ovalue <= 64'(now * ptm_pkg::NsPerTick);
              oval <= 1'b1; state <= S_IDLE;
            end
            ptm_pkg::REQ_GET: state <= S_GET;
            ptm_pkg::REQ_SET: begin
              if (ok) state <= S_DIV;
              else begin
                ovalue <= 64'd0; oval <= 1'b1; state <= S_IDLE;
              end
            end
            ptm_pkg::REQ_INT: begin
              if (now > last_time) last_time <= now;
              limit <= (now > ptm_pkg::Never - 64'(guard)) ? ptm_pkg::Never
                       : now + 64'(guard);
              best <= ptm_pkg::Never;
              idx <= '0;
              rd_valid <= 1'b0;
              hit <= '0;
              state <= S_SCAN;
            end
            default: begin
              ovalue <= ptm_pkg::Never; oval <= 1'b1; state <= S_IDLE;
            end
          endcase
        end
        S_GET: begin
          ovalue <= ok ? 64'(rdata * ptm_pkg::NsPerTick) : 64'd0;
          oval <= 1'b1; state <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            if (match > ticks) match <= ticks;
            ovalue <= 64'(ticks * ptm_pkg::NsPerTick);
            oval <= 1'b1; state <= S_IDLE;
          end
        end
        S_SCAN: begin
          // read one entry a cycle, compare the previous read
          rd_valid <= (idx < CW'(THREADS));
          rd_idx <= idx[AW-1:0];
          if (idx < CW'(THREADS)) idx <= idx + CW'(1);
          if (rd_valid) begin
            if (rdata != 64'd0 && rdata <= limit) hit[rd_idx] <= 1'b1;
            else if (rdata != 64'd0 && rdata < best) best <= rdata;
          end
          if (!rd_valid && idx == CW'(THREADS)) begin
            match <= best;
            idx <= '0;
            state <= S_NOTE;
          end
        end
        S_NOTE: begin
          // walk the hit vector, one notice per expired thread
          if (!oval || m_tready) begin
            if (idx == CW'(THREADS)) begin
              state <= S_FIN;
            end else begin
              idx <= idx + CW'(1);
              if (hit[idx[AW-1:0]]) begin
                ovalue <= 64'd0; okind <= 1'b1; othr <= 5'(idx);
                olast <= 1'b0; oval <= 1'b1;
              end
            end
          end
        end
        S_FIN: begin
          if (!oval || m_tready) begin
            ovalue <= match; okind <= 1'b0; othr <= 5'd0;
            olast <= 1'b1; oval <= 1'b1; state <= S_OUT;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = oval;
  assign m_tdata = {3'd0, match, othr, ovalue};
  assign m_tuser = okind;
  assign m_tlast = olast;

endmodule
